>>> rtl/chh_pkg.sv
// Shared types and constants of the hard-iron compass heading core.
// No dependencies; used by chh_cordic and compass_heading_hard_iron_core.
package chh_pkg;

	localparam int DW        = 18;  // offset-removed sample width
	localparam int PRE_SH    = 16;  // prescale shift before CORDIC
	localparam int XW        = 36;  // CORDIC x/y width incl. gain and sign
	localparam int ANG_W     = 32;  // binary angle, 2^32 = full turn
	localparam int HW        = 15;  // heading width
	localparam int TABLE_LEN = 24;
	localparam int STEP_W    = 5;

	localparam logic [HW-1:0] HEAD_FULL = 15'd23040;

	localparam logic [1:0] MODE_TRAIN   = 2'd0;
	localparam logic [1:0] MODE_HEADING = 2'd1;
	localparam logic [1:0] MODE_RELOAD  = 2'd2;

	localparam logic [1:0] REG_SEED_MIN_X = 2'd0;
	localparam logic [1:0] REG_SEED_MAX_X = 2'd1;
	localparam logic [1:0] REG_SEED_MIN_Y = 2'd2;
	localparam logic [1:0] REG_SEED_MAX_Y = 2'd3;

	localparam logic signed [15:0] SEED_MIN_X_RST = -16'sd699;
	localparam logic signed [15:0] SEED_MAX_X_RST = 16'sd1258;
	localparam logic signed [15:0] SEED_MIN_Y_RST = -16'sd1235;
	localparam logic signed [15:0] SEED_MAX_Y_RST = 16'sd757;

	typedef struct packed {
		logic                 start;
		logic                 take;
		logic signed [DW-1:0] dx;
		logic signed [DW-1:0] dy;
	} chh_req_t;

	typedef struct packed {
		logic          busy;
		logic          done;
		logic [HW-1:0] heading;
	} chh_sts_t;

	// atan(2^-i) as a 32-bit binary angle, rounded
	function automatic logic [ANG_W-1:0] atan_lut(input logic [STEP_W-1:0] i);
		logic [ANG_W-1:0] a;
		case (i)
			5'd0:    a = 32'h20000000;
			5'd1:    a = 32'h12E4051E;
			5'd2:    a = 32'h09FB385B;
			5'd3:    a = 32'h051111D4;
			5'd4:    a = 32'h028B0D43;
			5'd5:    a = 32'h0145D7E1;
			5'd6:    a = 32'h00A2F61E;
			5'd7:    a = 32'h00517C55;
			5'd8:    a = 32'h0028BE53;
			5'd9:    a = 32'h00145F2F;
			5'd10:   a = 32'h000A2F98;
			5'd11:   a = 32'h000517CC;
			5'd12:   a = 32'h00028BE6;
			5'd13:   a = 32'h000145F3;
			5'd14:   a = 32'h0000A2FA;
			5'd15:   a = 32'h0000517D;
			5'd16:   a = 32'h000028BE;
			5'd17:   a = 32'h0000145F;
			5'd18:   a = 32'h00000A30;
			5'd19:   a = 32'h00000518;
			5'd20:   a = 32'h0000028C;
			5'd21:   a = 32'h00000146;
			5'd22:   a = 32'h000000A3;
			5'd23:   a = 32'h00000051;
			default: a = '0;
		endcase
		return a;
	endfunction

endpackage

>>> rtl/compass_heading_hard_iron_core.sv
// Top level of the hard-iron calibrated compass heading core.
// Depends on chh_pkg and chh_cordic.
//
// Each input beat carries a mode in tuser and an X/Y magnetometer sample in tdata.
// A train beat widens the per-axis min/max window and a reload beat copies the
// seed registers into it; both finish in the accepting cycle and give no output.
// A heading beat removes the offset (min+max)/2, truncated toward zero, and runs
// an atan2 on one shared shift/add CORDIC stage, one iteration per cycle, then
// scales the angle with one multiply and a rounding step. s_axis_tready stays low
// from the accepting edge until the output beat is loaded, so the next beat is not
// taken before the heading is through the offset stage, the CORDIC iteration loop,
// the multiply and the rounding step, and a stalled output beat holds the next
// heading back further. The output beat is the heading in 1/64 degree, 0..23039.
// Mode 3 beats are dropped.
module compass_heading_hard_iron_core #(
	parameter int CORDIC_STEPS = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [31:0] s_axis_tdata,   // [15:0] mag_x, [31:16] mag_y
	input  logic [1:0]  s_axis_tuser,   // [1:0] mode
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [15:0] m_axis_tdata,   // [14:0] heading, [15] zero
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [1:0]  cfg_index,
	input  logic [15:0] cfg_data
);

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_OFS  = 2'd1;
	localparam logic [1:0] ST_WAIT = 2'd2;

	logic [1:0] state_q;
	logic signed [15:0] seed_min_x_q, seed_max_x_q, seed_min_y_q, seed_max_y_q;
	logic signed [15:0] min_x_q, max_x_q, min_y_q, max_y_q;
	logic signed [15:0] mag_x_q, mag_y_q;
	logic               m_valid_q;
	logic [14:0]        heading_q;

	logic signed [15:0] mx, my;
	logic signed [16:0] sum_x, sum_y, ofs_x, ofs_y;
	logic               s_acc, out_load;
	chh_pkg::chh_req_t  req;
	chh_pkg::chh_sts_t  sts;

	assign mx = s_axis_tdata[15:0];
	assign my = s_axis_tdata[31:16];
	assign s_axis_tready = (state_q == ST_IDLE);
	assign s_acc = s_axis_tvalid && s_axis_tready;
	assign cfg_ready = 1'b1;

	assign sum_x = {min_x_q[15], min_x_q} + {max_x_q[15], max_x_q};
	assign sum_y = {min_y_q[15], min_y_q} + {max_y_q[15], max_y_q};
	assign ofs_x = $signed(sum_x + {16'd0, sum_x[16]}) >>> 1;
	assign ofs_y = $signed(sum_y + {16'd0, sum_y[16]}) >>> 1;

	assign out_load = (state_q == ST_WAIT) && sts.done && (!m_valid_q || m_axis_tready);

	assign req.start = (state_q == ST_OFS);
	assign req.take  = out_load;
	assign req.dx    = {{2{mag_x_q[15]}}, mag_x_q} - {ofs_x[16], ofs_x};
	assign req.dy    = {{2{mag_y_q[15]}}, mag_y_q} - {ofs_y[16], ofs_y};

	chh_cordic #(
		.CORDIC_STEPS(CORDIC_STEPS)
	) u_cordic (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req),
		.sts    (sts)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			m_valid_q    <= 1'b0;
			seed_min_x_q <= chh_pkg::SEED_MIN_X_RST;
			seed_max_x_q <= chh_pkg::SEED_MAX_X_RST;
			seed_min_y_q <= chh_pkg::SEED_MIN_Y_RST;
			seed_max_y_q <= chh_pkg::SEED_MAX_Y_RST;
			min_x_q      <= chh_pkg::SEED_MIN_X_RST;
			max_x_q      <= chh_pkg::SEED_MAX_X_RST;
			min_y_q      <= chh_pkg::SEED_MIN_Y_RST;
			max_y_q      <= chh_pkg::SEED_MAX_Y_RST;
		end else begin
			if (cfg_valid) begin
				unique case (cfg_index)
					chh_pkg::REG_SEED_MIN_X: seed_min_x_q <= cfg_data;
					chh_pkg::REG_SEED_MAX_X: seed_max_x_q <= cfg_data;
					chh_pkg::REG_SEED_MIN_Y: seed_min_y_q <= cfg_data;
					chh_pkg::REG_SEED_MAX_Y: seed_max_y_q <= cfg_data;
					default: ;
				endcase
			end

			unique case (state_q)
				ST_IDLE: begin
					if (s_acc) begin
						unique case (s_axis_tuser)
							chh_pkg::MODE_TRAIN: begin
								if (mx > max_x_q)  max_x_q <= mx;
								if (mx <= min_x_q) min_x_q <= mx;
								if (my > max_y_q)  max_y_q <= my;
								if (my <= min_y_q) min_y_q <= my;
							end
							chh_pkg::MODE_HEADING: state_q <= ST_OFS;
							chh_pkg::MODE_RELOAD: begin
								min_x_q <= seed_min_x_q;
								max_x_q <= seed_max_x_q;
								min_y_q <= seed_min_y_q;
								max_y_q <= seed_max_y_q;
							end
							default: ;
						endcase
					end
				end
				ST_OFS:  state_q <= ST_WAIT;
				ST_WAIT: if (out_load) state_q <= ST_IDLE;
				default: state_q <= ST_IDLE;
			endcase

			if (out_load)
				m_valid_q <= 1'b1;
			else if (m_axis_tready)
				m_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s_acc) begin
			mag_x_q <= mx;
			mag_y_q <= my;
		end
		if (out_load)
			heading_q <= sts.heading;
	end

	assign m_axis_tvalid = m_valid_q;
	assign m_axis_tdata  = {1'b0, heading_q};

	a_heading_starts: assert property (@(posedge clk) disable iff (!arst_n)
		(s_acc && s_axis_tuser == chh_pkg::MODE_HEADING) |=> (state_q == ST_OFS))
		else $error("heading beat did not start offset stage");
	a_done_while_wait: assert property (@(posedge clk) disable iff (!arst_n)
		sts.done |-> (state_q == ST_WAIT))
		else $error("CORDIC result with no heading pending");
	a_idle_unit: assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tready |-> !sts.busy)
		else $error("input ready while CORDIC busy");
	a_heading_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> (m_axis_tdata[14:0] < chh_pkg::HEAD_FULL))
		else $error("heading out of range");

endmodule

>>> rtl/chh_cordic.sv
// Iterative vectoring CORDIC: atan2 of an offset-removed sample, scaled to 1/64 degree.
// Depends on chh_pkg. One shift/add stage reused for every iteration.
module chh_cordic #(
	parameter int CORDIC_STEPS = 16
) (
	input  logic             clk,
	input  logic             arst_n,
	input  chh_pkg::chh_req_t req,
	output chh_pkg::chh_sts_t sts
);

	localparam int NSTEPS = (CORDIC_STEPS > chh_pkg::TABLE_LEN) ?
		chh_pkg::TABLE_LEN : CORDIC_STEPS;
	localparam logic [chh_pkg::STEP_W-1:0] LAST = chh_pkg::STEP_W'(NSTEPS - 1);
	localparam int PW = chh_pkg::ANG_W + chh_pkg::HW;

	localparam logic [2:0] C_IDLE = 3'd0;
	localparam logic [2:0] C_ROT  = 3'd1;
	localparam logic [2:0] C_MUL  = 3'd2;
	localparam logic [2:0] C_RND  = 3'd3;
	localparam logic [2:0] C_DONE = 3'd4;

	logic [2:0]                          cst_q;
	logic [chh_pkg::STEP_W-1:0]          i_q;
	logic signed [chh_pkg::XW-1:0]       x_q, y_q;
	logic [chh_pkg::ANG_W-1:0]           ang_q;
	logic                                zero_q;
	logic [PW-1:0]                       prod_q;
	logic [chh_pkg::HW-1:0]              heading_q;

	logic signed [chh_pkg::XW-1:0] dx_w, dy_w, xs, ys;
	logic [chh_pkg::ANG_W-1:0]     atan_v;
	logic [PW:0]                   rnd;
	logic [PW-chh_pkg::ANG_W:0]    h;

	assign dx_w = {{(chh_pkg::XW-chh_pkg::DW){req.dx[chh_pkg::DW-1]}}, req.dx} <<< chh_pkg::PRE_SH;
	assign dy_w = {{(chh_pkg::XW-chh_pkg::DW){req.dy[chh_pkg::DW-1]}}, req.dy} <<< chh_pkg::PRE_SH;
	assign xs     = x_q >>> i_q;
	assign ys     = y_q >>> i_q;
	assign atan_v = chh_pkg::atan_lut(i_q);
	assign rnd    = {1'b0, prod_q} + (PW+1)'(33'h0_8000_0000);
	assign h      = rnd[PW:chh_pkg::ANG_W];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cst_q <= C_IDLE;
		end else begin
			unique case (cst_q)
				C_IDLE: if (req.start) cst_q <= C_ROT;
				C_ROT:  if (i_q == LAST) cst_q <= C_MUL;
				C_MUL:  cst_q <= C_RND;
				C_RND:  cst_q <= C_DONE;
				C_DONE: if (req.take) cst_q <= C_IDLE;
				default: cst_q <= C_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		unique case (cst_q)
			C_IDLE: begin
				i_q    <= '0;
				zero_q <= (req.dx == '0) && (req.dy == '0);
				if (req.dx[chh_pkg::DW-1]) begin
					x_q   <= -dx_w;
					y_q   <= -dy_w;
					ang_q <= 32'h8000_0000;
				end else begin
					x_q   <= dx_w;
					y_q   <= dy_w;
					ang_q <= '0;
				end
			end
			C_ROT: begin
				i_q <= i_q + 1'b1;
				if (!y_q[chh_pkg::XW-1]) begin
					x_q   <= x_q + ys;
					y_q   <= y_q - xs;
					ang_q <= ang_q + atan_v;
				end else begin
					x_q   <= x_q - ys;
					y_q   <= y_q + xs;
					ang_q <= ang_q - atan_v;
				end
			end
			C_MUL: prod_q <= PW'(ang_q) * PW'(chh_pkg::HEAD_FULL);
			C_RND: begin
				if (zero_q || (h >= (PW-chh_pkg::ANG_W+1)'(chh_pkg::HEAD_FULL)))
					heading_q <= '0;
				else
					heading_q <= h[chh_pkg::HW-1:0];
			end
			default: ;
		endcase
	end

	assign sts.busy    = (cst_q != C_IDLE);
	assign sts.done    = (cst_q == C_DONE);
	assign sts.heading = heading_q;

	a_iter_range: assert property (@(posedge clk) disable iff (!arst_n)
		(cst_q == C_ROT) |-> (i_q <= LAST))
		else $error("CORDIC iteration past last step");
	a_mul_after_rot: assert property (@(posedge clk) disable iff (!arst_n)
		(cst_q == C_MUL) |-> ($past(cst_q) == C_ROT && $past(i_q) == LAST))
		else $error("multiply entered before rotations finished");
	a_take_only_done: assert property (@(posedge clk) disable iff (!arst_n)
		(cst_q == C_DONE && req.take) |=> (cst_q == C_IDLE))
		else $error("result not released on take");

endmodule

>>> tb/compass_heading_hard_iron_core_tb.sv
// Self-checking bench for compass_heading_hard_iron_core: random stream traffic with
// stalls on both sides, seed register phases, and an in-bench CORDIC heading predictor.
// Depends on chh_pkg and the core RTL.
module compass_heading_hard_iron_core_tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int STEPS          = 16;
	localparam int RAND_PER_PHASE = 270;
	localparam int HOLD_CYCLES    = 400;
	localparam int DRAIN_LIMIT    = 200000;
	localparam logic [1:0] MODE_UNUSED = 2'd3;

	// atan(2^-i) as a 32-bit binary angle, entry 0 in the low word
	localparam logic [24*32-1:0] ATAN_BAM = {
		32'h00000051, 32'h000000A3, 32'h00000146, 32'h0000028C,
		32'h00000518, 32'h00000A30, 32'h0000145F, 32'h000028BE,
		32'h0000517D, 32'h0000A2FA, 32'h000145F3, 32'h00028BE6,
		32'h000517CC, 32'h000A2F98, 32'h00145F2F, 32'h0028BE53,
		32'h00517C55, 32'h00A2F61E, 32'h0145D7E1, 32'h028B0D43,
		32'h051111D4, 32'h09FB385B, 32'h12E4051E, 32'h20000000
	};

	typedef struct packed {
		logic [1:0]          mode;
		logic signed [15:0]  mx;
		logic signed [15:0]  my;
	} mag_beat_t;

	logic        clk;
	logic        arst_n        = 1'b0;
	logic        s_axis_tvalid = 1'b0;
	logic        s_axis_tready;
	logic [31:0] s_axis_tdata  = '0;
	logic [1:0]  s_axis_tuser  = '0;
	logic        m_axis_tvalid;
	logic        m_axis_tready = 1'b0;
	logic [15:0] m_axis_tdata;
	logic        cfg_valid     = 1'b0;
	logic        cfg_ready;
	logic [1:0]  cfg_index     = '0;
	logic [15:0] cfg_data      = '0;

	compass_heading_hard_iron_core #(.CORDIC_STEPS(STEPS)) DUT (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data)
	);

	// predictor state
	logic signed [15:0] seed_min_x = chh_pkg::SEED_MIN_X_RST;
	logic signed [15:0] seed_max_x = chh_pkg::SEED_MAX_X_RST;
	logic signed [15:0] seed_min_y = chh_pkg::SEED_MIN_Y_RST;
	logic signed [15:0] seed_max_y = chh_pkg::SEED_MAX_Y_RST;
	logic signed [15:0] win_min_x  = chh_pkg::SEED_MIN_X_RST;
	logic signed [15:0] win_max_x  = chh_pkg::SEED_MAX_X_RST;
	logic signed [15:0] win_min_y  = chh_pkg::SEED_MIN_Y_RST;
	logic signed [15:0] win_max_y  = chh_pkg::SEED_MAX_Y_RST;

	mag_beat_t                beats_to_send [$];
	logic [chh_pkg::HW-1:0]   headings_due [$];

	int items_queued = 0;
	int beats_taken  = 0;
	int n_train = 0, n_reload = 0, n_dropped = 0, n_heading = 0, n_checked = 0, n_cfg = 0;
	int errors = 0;

	bit src_idle = 1'b1;
	bit snk_idle = 1'b1;
	int src_gap  = 0;
	int snk_gap  = 0;
	int hold_req = 0;
	int hold_done = 0;
	int hold_left = 0;

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	initial begin
		#40_000_000;
		$display("Some tests failed");
		$finish;
	end

	function automatic logic [chh_pkg::HW-1:0] cordic_heading(input int dx, input int dy);
		longint vx, vy, sx, sy;
		logic [31:0] ang;
		logic [63:0] scaled;
		int n, i;
		if (dx == 0 && dy == 0)
			return '0;
		vx = longint'(dx) * 65536;
		vy = longint'(dy) * 65536;
		ang = '0;
		if (vx < 0) begin
			vx = -vx;
			vy = -vy;
			ang = 32'h80000000;
		end
		n = (STEPS > chh_pkg::TABLE_LEN) ? chh_pkg::TABLE_LEN : STEPS;
		for (i = 0; i < n; i++) begin
			sx = vx >>> i;
			sy = vy >>> i;
			if (vy >= 0) begin
				vx = vx + sy;
				vy = vy - sx;
				ang = ang + ATAN_BAM[i*32 +: 32];
			end else begin
				vx = vx - sy;
				vy = vy + sx;
				ang = ang - ATAN_BAM[i*32 +: 32];
			end
		end
		scaled = (64'(ang) * 64'(chh_pkg::HEAD_FULL) + 64'h8000_0000) >> 32;
		if (scaled >= 64'(chh_pkg::HEAD_FULL))
			scaled = '0;
		return scaled[chh_pkg::HW-1:0];
	endfunction

	task automatic take_sample(input logic [1:0] mode, input logic signed [15:0] mx,
			input logic signed [15:0] my);
		int ox, oy;
		case (mode)
			chh_pkg::MODE_TRAIN: begin
				if (mx > win_max_x) win_max_x = mx;
				if (mx <= win_min_x) win_min_x = mx;
				if (my > win_max_y) win_max_y = my;
				if (my <= win_min_y) win_min_y = my;
				n_train++;
			end
			chh_pkg::MODE_HEADING: begin
				ox = (int'(win_min_x) + int'(win_max_x)) / 2;
				oy = (int'(win_min_y) + int'(win_max_y)) / 2;
				headings_due.push_back(cordic_heading(int'(mx) - ox, int'(my) - oy));
				n_heading++;
			end
			chh_pkg::MODE_RELOAD: begin
				win_min_x = seed_min_x;
				win_max_x = seed_max_x;
				win_min_y = seed_min_y;
				win_max_y = seed_max_y;
				n_reload++;
			end
			default: n_dropped++;
		endcase
	endtask

	task automatic flag_mismatch(input string what, input int got, input int want);
		$display("MISMATCH %s: got %0d, expected %0d at %0t", what, got, want, $realtime);
		errors++;
	endtask

	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 55) return 0;
		if (r < 85) return $urandom_range(1, 4);
		if (r < 96) return $urandom_range(5, 20);
		return $urandom_range(30, 80);
	endfunction

	// sender
	always @(posedge clk) begin : src_drv
		logic drive_v;
		drive_v = s_axis_tvalid;
		if (arst_n && s_axis_tvalid && s_axis_tready) begin
			take_sample(s_axis_tuser, s_axis_tdata[15:0], s_axis_tdata[31:16]);
			beats_taken++;
			drive_v = 1'b0;
			src_gap = src_idle ? pick_gap() : 0;
		end
		if (!drive_v && arst_n) begin
			if (src_gap > 0) begin
				src_gap--;
			end else if (beats_to_send.size() > 0) begin
				mag_beat_t b;
				b = beats_to_send.pop_front();
				drive_v = 1'b1;
				s_axis_tdata <= {b.my, b.mx};
				s_axis_tuser <= b.mode;
			end
		end
		s_axis_tvalid <= drive_v;
	end

	// receiver and checker
	always @(posedge clk) begin : snk_mon
		logic rdy;
		logic [chh_pkg::HW-1:0] want;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			if (headings_due.size() == 0) begin
				flag_mismatch("heading beat with none pending", m_axis_tdata, -1);
			end else begin
				want = headings_due.pop_front();
				if (m_axis_tdata !== {1'b0, want})
					flag_mismatch("heading", m_axis_tdata, want);
				n_checked++;
			end
		end
		if (hold_req != hold_done) begin
			hold_done = hold_req;
			hold_left = HOLD_CYCLES;
		end
		if (hold_left > 0) begin
			hold_left--;
			rdy = 1'b0;
		end else if (snk_gap > 0) begin
			snk_gap--;
			rdy = 1'b0;
		end else begin
			rdy = 1'b1;
			if (snk_idle && $urandom_range(0, 7) == 0) begin
				snk_gap = pick_gap();
				if (snk_gap > 0) rdy = 1'b0;
			end
		end
		m_axis_tready <= rdy;
	end

	task automatic queue_beat(input logic [1:0] mode, input int mx, input int my);
		mag_beat_t b;
		b.mode = mode;
		b.mx = 16'(mx);
		b.my = 16'(my);
		beats_to_send.push_back(b);
		items_queued++;
	endtask

	function automatic int rand_axis();
		case ($urandom_range(0, 3))
			0: return int'($signed(16'($urandom)));
			3: begin
				case ($urandom_range(0, 3))
					0: return -32768;
					1: return 32767;
					2: return 0;
					default: return -1;
				endcase
			end
			default: return $urandom_range(0, 6000) - 3000;
		endcase
	endfunction

	task automatic queue_random();
		int r;
		logic [1:0] mode;
		r = $urandom_range(0, 99);
		if (r < 48) mode = chh_pkg::MODE_HEADING;
		else if (r < 89) mode = chh_pkg::MODE_TRAIN;
		else if (r < 95) mode = chh_pkg::MODE_RELOAD;
		else mode = MODE_UNUSED;
		queue_beat(mode, rand_axis(), rand_axis());
	endtask

	task automatic write_seed(input logic [1:0] idx, input logic signed [15:0] val);
		@(posedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		case (idx)
			chh_pkg::REG_SEED_MIN_X: seed_min_x = val;
			chh_pkg::REG_SEED_MAX_X: seed_max_x = val;
			chh_pkg::REG_SEED_MIN_Y: seed_min_y = val;
			default:                 seed_max_y = val;
		endcase
		n_cfg++;
	endtask

	task automatic wait_idle();
		do @(posedge clk); while (beats_taken != items_queued || headings_due.size() != 0);
		repeat (STEPS + 10) @(posedge clk);
	endtask

	initial begin : stim
		int ph, k, cx, cy;
		logic signed [15:0] s0, s1, s2, s3;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		for (ph = 0; ph < 6; ph++) begin
			src_idle = (ph != 3);
			snk_idle = (ph != 3);
			if (ph == 0) begin
				// reset window: offset is (279, -239)
				queue_beat(chh_pkg::MODE_HEADING, 279, -239);
				queue_beat(chh_pkg::MODE_HEADING, 1279, -239);
				queue_beat(chh_pkg::MODE_HEADING, -721, -239);
				queue_beat(chh_pkg::MODE_HEADING, 279, 761);
				queue_beat(chh_pkg::MODE_HEADING, 279, -1239);
				queue_beat(chh_pkg::MODE_HEADING, 32767, -240);   // just under a full turn
				queue_beat(chh_pkg::MODE_HEADING, 32767, 32767);
				queue_beat(chh_pkg::MODE_HEADING, -32768, -32768);
				queue_beat(chh_pkg::MODE_HEADING, 32767, -32768);
				queue_beat(chh_pkg::MODE_HEADING, -32768, 32767);
				queue_beat(chh_pkg::MODE_HEADING, -32768, -239);
				queue_beat(MODE_UNUSED, 12345, -1);
				queue_beat(chh_pkg::MODE_TRAIN, -699, -1235);
				queue_beat(chh_pkg::MODE_TRAIN, 1258, 757);
				queue_beat(chh_pkg::MODE_HEADING, 279, -239);
				queue_beat(chh_pkg::MODE_TRAIN, 32767, -32768);
				queue_beat(chh_pkg::MODE_TRAIN, -32768, 32767);
				queue_beat(chh_pkg::MODE_HEADING, 0, 0);
				queue_beat(chh_pkg::MODE_HEADING, 100, -1);
				queue_beat(chh_pkg::MODE_RELOAD, -5, 5);
				queue_beat(chh_pkg::MODE_HEADING, 279, -239);
				queue_beat(chh_pkg::MODE_TRAIN, 2000, -3000);
				queue_beat(chh_pkg::MODE_HEADING, 5, 5);
				queue_beat(chh_pkg::MODE_RELOAD, 0, 0);
				queue_beat(chh_pkg::MODE_HEADING, 280, -239);
			end else begin
				wait_idle();
				case (ph)
					1: begin s0 = -16'sd32768; s1 = 16'sd32767; s2 = -16'sd32768; s3 = 16'sd32767; end
					2: begin s0 = 16'sd32767; s1 = -16'sd32768; s2 = 16'sd32767; s3 = -16'sd32768; end
					3: begin s0 = 16'sd32767; s1 = 16'sd32767; s2 = 16'sd32767; s3 = 16'sd32767; end
					4: begin
						s0 = -16'sd32768; s1 = -16'sd32768; s2 = -16'sd32768; s3 = -16'sd32768;
					end
					default: begin
						s0 = 16'($urandom); s1 = 16'($urandom);
						s2 = 16'($urandom); s3 = 16'($urandom);
					end
				endcase
				write_seed(chh_pkg::REG_SEED_MAX_Y, s3);
				write_seed(chh_pkg::REG_SEED_MIN_X, s0);
				write_seed(chh_pkg::REG_SEED_MIN_Y, s2);
				write_seed(chh_pkg::REG_SEED_MAX_X, s1);
				cx = (int'(s0) + int'(s1)) / 2;
				cy = (int'(s2) + int'(s3)) / 2;
				queue_beat(chh_pkg::MODE_RELOAD, rand_axis(), rand_axis());
				queue_beat(chh_pkg::MODE_HEADING, cx, cy);    // zero vector
			end
			if (ph == 1) begin
				// output held off while headings keep coming
				hold_req++;
				for (k = 0; k < 30; k++)
					queue_beat(chh_pkg::MODE_HEADING, rand_axis(), rand_axis());
			end
			for (k = 0; k < RAND_PER_PHASE; k++)
				queue_random();
		end
		k = 0;
		while ((beats_taken != items_queued || headings_due.size() != 0) && k < DRAIN_LIMIT) begin
			@(posedge clk);
			k++;
		end
		repeat (STEPS + 10) @(posedge clk);
		if (headings_due.size() != 0)
			flag_mismatch("headings never delivered", 0, headings_due.size());
		$display("Covered %0d headings (%0d checked), %0d train, %0d reload, %0d mode-3 beats",
			n_heading, n_checked, n_train, n_reload, n_dropped);
		$display("Seed writes: %0d over six window settings incl. extremes and inverted",
			n_cfg);
		if (errors == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

endmodule
